>>> rtl/tans_pkg.sv
`default_nettype none

package tans_pkg;

    // table geometry
    localparam int TABLE_SIZE  = 512;
    localparam int TABLE_BITS  = 9;
    localparam int STATE_BITS  = TABLE_BITS + 1;
    localparam int SPREAD_STEP = 343;
    localparam int ALPHABET    = 256;
    localparam int WEIGHT_MAX  = 16;
    localparam int WCODE_BITS  = 5;
    localparam int COUNT_BITS  = 4;

    // input transfer payload
    typedef struct packed {
        logic [7:0] symbol;
        logic       block_end;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [TABLE_BITS-1:0] renorm_bits;
        logic [COUNT_BITS-1:0] renorm_count;
        logic                  trailer_valid;
        logic [STATE_BITS-1:0] final_state;
        logic [WCODE_BITS-1:0] weight_echo;
    } t_out_item;

    // renormalization result handed to the top level
    typedef struct packed {
        logic [TABLE_BITS-1:0] bits;
        logic [COUNT_BITS-1:0] count;
        logic [TABLE_BITS-1:0] index;
    } t_renorm;

endpackage

`default_nettype wire

>>> rtl/tans_symbol_encoder.sv
`default_nettype none

// tANS byte encoder, 512-state spread table in one synchronous memory.
// Result: the renorm result is held in the pending stage, then registered into the output register.
// A new byte is taken only once the pending byte has retired; the spread-table read feeds the next state.
// Reset: coder state 512, zero_weight 0; then a fill sweep of the
// spread table during which no input is taken (config writes still taken).
module tans_symbol_encoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tans_pkg::WCODE_BITS-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tans_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tans_pkg::t_out_item                    o_out_data
);

    logic [tans_pkg::WCODE_BITS-1:0]   r_zero_weight;
    logic [tans_pkg::STATE_BITS-1:0]   r_state;
    logic                              r_busy;
    tans_pkg::t_renorm                 r_pend;
    logic                              r_pend_last;
    logic [tans_pkg::WCODE_BITS-1:0]   r_pend_d;
    logic                              r_out_valid;
    tans_pkg::t_out_item               r_out;

    logic [tans_pkg::WCODE_BITS-1:0]   w_d_eff;
    tans_pkg::t_renorm                 w_renorm;
    logic [tans_pkg::TABLE_BITS-1:0]   w_rd_data;
    logic                              w_fill_done;
    logic                              w_in_xfer;
    logic                              w_out_free;
    logic                              w_retire;
    logic [tans_pkg::STATE_BITS-1:0]   n_state;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_weight <= '0;
        end else if (i_cfg_valid) begin
            r_zero_weight <= i_cfg_data;
        end
    end

    assign w_d_eff = (r_zero_weight > tans_pkg::WCODE_BITS'(tans_pkg::WEIGHT_MAX))
                   ? tans_pkg::WCODE_BITS'(tans_pkg::WEIGHT_MAX) : r_zero_weight;

    tans_renorm u_renorm (
        .i_symbol      (i_in_data.symbol),
        .i_weight_code (w_d_eff),
        .i_state       (r_state),
        .o_result      (w_renorm)
    );

    tans_spread_mem u_spread (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_in_xfer),
        .i_rd_addr   (w_renorm.index),
        .o_rd_data   (w_rd_data),
        .o_fill_done (w_fill_done)
    );

    // handshake
    assign o_in_ready = w_fill_done && !r_busy;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_retire   = r_busy && w_out_free;
    assign n_state    = {1'b1, w_rd_data};

    // pending stage: waits for the table read, retires into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_state     <= tans_pkg::STATE_BITS'(tans_pkg::TABLE_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (w_retire) begin
                r_busy <= 1'b0;
            end
            if (w_retire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pend      <= w_renorm;
            r_pend_last <= i_in_data.block_end;
            r_pend_d    <= w_d_eff;
        end
        if (w_retire) begin
            r_out.renorm_bits   <= r_pend.bits;
            r_out.renorm_count  <= r_pend.count;
            r_out.trailer_valid <= r_pend_last;
            r_out.final_state   <= r_pend_last ? n_state : '0;
            r_out.weight_echo   <= r_pend_last ? r_pend_d : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // coder state never leaves the upper half of the state range
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state[tans_pkg::STATE_BITS-1] == 1'b1)
        else $error("coder state below table size");

    // an accepted byte is held in the pending stage next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_busy)
        else $error("accepted byte not pending");

    // a blocked pending byte keeps the state untouched
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_out_valid && !i_out_ready) |=> (r_busy && $stable(r_state)))
        else $error("state changed while result stalled");

    // no results before the spread table is filled
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fill_done |-> (!r_out_valid && !r_busy))
        else $error("activity during table fill");

endmodule

`default_nettype wire

>>> rtl/tans_renorm.sv
`default_nettype none

// Symbol weight/offset lookup, renormalization shift and spread-table index.
module tans_renorm (
    input  wire logic [7:0]                         i_symbol,
    input  wire logic [tans_pkg::WCODE_BITS-1:0]    i_weight_code,
    input  wire logic [tans_pkg::STATE_BITS-1:0]    i_state,
    output tans_pkg::t_renorm                       o_result
);

    logic [8:0]                          w_d16;
    logic [8:0]                          w_n2;
    logic [8:0]                          w_w0;
    logic [8:0]                          w_weight;
    logic [7:0]                          w_m;
    logic [tans_pkg::STATE_BITS-1:0]     w_offset;
    logic [tans_pkg::STATE_BITS-1:0]     w_limit;
    logic [tans_pkg::COUNT_BITS-1:0]     w_count;
    logic [tans_pkg::STATE_BITS-1:0]     w_shifted;
    logic [tans_pkg::STATE_BITS-1:0]     w_sum;
    logic [tans_pkg::STATE_BITS-1:0]     w_mask;
    logic [tans_pkg::STATE_BITS-1:0]     w_low;

    // weights: symbol 0 takes the zero share, the rest get 2 or 1
    assign w_d16 = {i_weight_code, 4'b0000};
    assign w_n2  = 9'(tans_pkg::ALPHABET) - w_d16;
    assign w_w0  = (i_weight_code == '0) ? 9'd2 : (w_d16 + 9'd1);
    assign w_m   = i_symbol - 8'd1;

    always_comb begin
        if (i_symbol == 8'd0) begin
            w_weight = w_w0;
        end else if ({1'b0, i_symbol} <= w_n2) begin
            w_weight = 9'd2;
        end else begin
            w_weight = 9'd1;
        end
    end

    // cumulative offset of the symbol
    always_comb begin
        if (i_symbol == 8'd0) begin
            w_offset = '0;
        end else if ({1'b0, w_m} <= w_n2) begin
            w_offset = {1'b0, w_w0} + {1'b0, w_m, 1'b0};
        end else begin
            w_offset = {1'b0, w_w0} + {1'b0, w_n2} + {2'b00, w_m};
        end
    end

    assign w_limit = {w_weight, 1'b0} - 10'd1;

    // smallest shift that brings the state to or under the limit
    always_comb begin
        w_count = 4'd9;
        for (int k = 9; k >= 0; k--) begin
            if ((i_state >> k) <= w_limit) begin
                w_count = 4'(k);
            end
        end
    end

    assign w_shifted = i_state >> w_count;
    assign w_sum     = w_offset + w_shifted - {1'b0, w_weight};
    assign w_mask    = (10'd1 << w_count) - 10'd1;
    assign w_low     = i_state & w_mask;

    assign o_result.bits  = w_low[tans_pkg::TABLE_BITS-1:0];
    assign o_result.count = w_count;
    assign o_result.index = w_sum[tans_pkg::TABLE_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/tans_spread_mem.sv
`default_nettype none

// Spread table memory; filled by a sweep after reset, then read-only.
// Entry (343*k mod 512) holds k; the state value is 512 + k.
module tans_spread_mem (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_rd_en,
    input  wire logic [tans_pkg::TABLE_BITS-1:0]   i_rd_addr,
    output logic      [tans_pkg::TABLE_BITS-1:0]   o_rd_data,
    output logic                                   o_fill_done
);

    logic [tans_pkg::TABLE_BITS-1:0] r_mem [tans_pkg::TABLE_SIZE];
    logic [tans_pkg::TABLE_BITS-1:0] r_fill_pos;
    logic [tans_pkg::TABLE_BITS-1:0] r_fill_k;
    logic                            r_fill_done;
    logic [tans_pkg::TABLE_BITS-1:0] n_fill_pos;

    assign n_fill_pos = r_fill_pos + tans_pkg::TABLE_BITS'(tans_pkg::SPREAD_STEP);

    // fill sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_pos  <= '0;
            r_fill_k    <= '0;
            r_fill_done <= 1'b0;
        end else if (!r_fill_done) begin
            r_fill_pos <= n_fill_pos;
            r_fill_k   <= r_fill_k + 1'b1;
            if (r_fill_k == '1) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (!r_fill_done) begin
            r_mem[r_fill_pos] <= r_fill_k;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_fill_done = r_fill_done;

endmodule

`default_nettype wire
